>>> rtl/sensor_window_statistics_assert.svh
`ifndef SENSOR_WINDOW_STATISTICS_ASSERT_SVH
`define SENSOR_WINDOW_STATISTICS_ASSERT_SVH

// condition must hold at every edge out of reset
`define SWST_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("swst check failed");

// consequent must hold in the cycle after the antecedent
`define SWST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swst check failed");

`endif

>>> rtl/swst_pkg.sv
`default_nettype none
package swst_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int CNT_W      = 11;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam logic [2:0] ST_GOOD    = 3'd0;
    localparam logic [2:0] ST_MISSING = 3'd1;
    localparam logic [2:0] ST_RANGE   = 3'd3;

    localparam logic [10:0] EXPECTED_RESET = 11'd10;

    typedef enum logic [2:0] {
        S_ACC,
        S_TDIV,
        S_CDIV,
        S_VDIV,
        S_SQRT,
        S_CREST,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic               eow;
        logic               t_ok;
        logic signed [15:0] t_val;
        logic [2:0]         t_bad;
        logic               c_ok;
        logic signed [15:0] c_val;
        logic [2:0]         c_bad;
        logic               v_ok;
        logic [18:0]        v_mag;
        logic [37:0]        v_sq;
        logic [2:0]         v_bad;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_head_t;

    function automatic logic [2:0] quality(input logic [2:0] worst,
                                           input logic [CNT_W-1:0] cnt,
                                           input logic [10:0] expected);
        if (worst == ST_GOOD && cnt < expected)
            return ST_MISSING;
        return worst;
    endfunction

endpackage
`default_nettype wire

>>> rtl/swst_front.sv
`default_nettype none
module swst_front
    import swst_pkg::*;
(
    input  wire logic [63:0] tdata,
    input  wire logic        tlast,
    output q_entry_t         entry
);

    logic signed [15:0] t;
    logic signed [15:0] c;
    logic signed [19:0] v;
    logic [2:0]         ts;
    logic [2:0]         cs;
    logic [2:0]         vs;
    logic [19:0]        mag;

    always_comb
    begin
        t   = tdata[15:0];
        ts  = tdata[18:16];
        c   = tdata[34:19];
        cs  = tdata[37:35];
        v   = tdata[57:38];
        vs  = tdata[60:58];
        mag = v[19] ? 20'(-v) : 20'(v);

        entry.eow   = tlast;
        entry.t_ok  = (ts == ST_GOOD) && (t >= -16'sd8000) && (t <= 16'sd20000);
        entry.t_val = t;
        entry.t_bad = (ts == ST_GOOD) ? ST_RANGE : ts;
        entry.c_ok  = (cs == ST_GOOD) && (c >= -16'sd100) && (c <= 16'sd10000);
        entry.c_val = c;
        entry.c_bad = (cs == ST_GOOD) ? ST_RANGE : cs;
        entry.v_ok  = (vs == ST_GOOD) && (mag <= 20'd400000);
        entry.v_mag = mag[18:0];
        entry.v_sq  = 38'(mag[18:0]) * 38'(mag[18:0]);
        entry.v_bad = (vs == ST_GOOD) ? ST_RANGE : vs;
    end

endmodule
`default_nettype wire

>>> rtl/swst_queue.sv
`default_nettype none
`include "sensor_window_statistics_assert.svh"
module swst_queue
    import swst_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  q_entry_t      push_entry,
    output logic          full,
    input  wire logic     pop,
    output q_head_t       head
);

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_reg;
    logic [QPTR_W-1:0]   rd_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = mem_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    `SWST_ALWAYS(a_no_overfill, !(push && full))
    `SWST_ALWAYS(a_no_pop_empty, !(pop && count_reg == '0))
    `SWST_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule
`default_nettype wire

>>> rtl/swst_divider.sv
`default_nettype none
module swst_divider
    import swst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    input  wire logic [18:0] divisor,
    output logic             done,
    output logic [47:0]      quotient
);

    logic [47:0] q_reg;
    logic [18:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [19:0] sh;
    logic        ge;

    assign sh       = {rem_reg, q_reg[47]};
    assign ge       = (sh >= {1'b0, divisor});
    assign done     = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 19'(sh - {1'b0, divisor}) : sh[18:0];
            q_reg   <= {q_reg[46:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd47)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/swst_back.sv
`default_nettype none
module swst_back
    import swst_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  q_head_t           head,
    output logic              pop,
    input  wire logic [10:0]  expected,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [127:0]      m_tdata
);

    state_t state_reg, state_next;

    logic signed [25:0] t_tot_reg, t_tot_next;
    logic signed [24:0] c_tot_reg, c_tot_next;
    logic [47:0]        v_tot_reg, v_tot_next;
    logic [18:0]        peak_reg, peak_next;
    logic [CNT_W-1:0]   t_cnt_reg, t_cnt_next, c_cnt_reg, c_cnt_next, v_cnt_reg, v_cnt_next;
    logic [2:0]         t_w_reg, t_w_next, c_w_reg, c_w_next, v_w_reg, v_w_next;

    logic signed [25:0] st_reg;
    logic signed [24:0] sc_reg;
    logic [47:0]        sv_reg;
    logic [18:0]        sp_reg;
    logic [CNT_W-1:0]   stc_reg, scc_reg, svc_reg;
    logic [2:0]         stw_reg, scw_reg, svw_reg;
    logic [10:0]        exp_reg;

    logic [15:0] t_mean_reg;
    logic [14:0] c_mean_reg;
    logic [37:0] x_reg;
    logic [21:0] rem_reg;
    logic [18:0] rms_reg;
    logic [4:0]  sq_cnt_reg;
    logic [15:0] crest_reg;
    logic        go_reg;
    logic        m_valid_reg;
    logic [127:0] m_data_reg;

    logic        div_done;
    logic [47:0] div_q;
    logic [47:0] div_a;
    logic [18:0] div_b;
    logic [21:0] r4;
    logic [21:0] trial;
    logic        sq_ge;
    logic        load_out;
    logic        crest_ok;

    swst_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (go_reg),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign pop      = (state_reg == S_ACC) && head.valid;
    assign load_out = (state_reg == S_EMIT) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign r4       = {rem_reg[19:0], x_reg[37:36]};
    assign trial    = {1'b0, rms_reg, 2'b01};
    assign sq_ge    = (r4 >= trial);
    assign crest_ok = (rms_reg != '0);

    always_comb
    begin
        div_a = '0;
        div_b = '0;
        case (state_reg)
            S_TDIV:
            begin
                div_a = 48'(st_reg[25] ? -st_reg : st_reg);
                div_b = 19'(stc_reg);
            end
            S_CDIV:
            begin
                div_a = 48'(sc_reg[24] ? -sc_reg : sc_reg);
                div_b = 19'(scc_reg);
            end
            S_VDIV:
            begin
                div_a = sv_reg;
                div_b = 19'(svc_reg);
            end
            S_CREST:
            begin
                div_a = {19'd0, sp_reg, 10'd0};
                div_b = rms_reg;
            end
            default:
            begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    always_comb
    begin
        t_tot_next = t_tot_reg;
        c_tot_next = c_tot_reg;
        v_tot_next = v_tot_reg;
        peak_next  = peak_reg;
        t_cnt_next = t_cnt_reg;
        c_cnt_next = c_cnt_reg;
        v_cnt_next = v_cnt_reg;
        t_w_next   = t_w_reg;
        c_w_next   = c_w_reg;
        v_w_next   = v_w_reg;
        if (head.entry.t_ok)
        begin
            if (t_cnt_reg < CNT_W'(MAX_WINDOW))
            begin
                t_tot_next = t_tot_reg + 26'(head.entry.t_val);
                t_cnt_next = t_cnt_reg + 1'b1;
            end
        end
        else if (head.entry.t_bad > t_w_reg)
            t_w_next = head.entry.t_bad;
        if (head.entry.c_ok)
        begin
            if (c_cnt_reg < CNT_W'(MAX_WINDOW))
            begin
                c_tot_next = c_tot_reg + 25'(head.entry.c_val);
                c_cnt_next = c_cnt_reg + 1'b1;
            end
        end
        else if (head.entry.c_bad > c_w_reg)
            c_w_next = head.entry.c_bad;
        if (head.entry.v_ok)
        begin
            if (v_cnt_reg < CNT_W'(MAX_WINDOW))
            begin
                v_tot_next = v_tot_reg + 48'(head.entry.v_sq);
                v_cnt_next = v_cnt_reg + 1'b1;
                if (head.entry.v_mag > peak_reg)
                    peak_next = head.entry.v_mag;
            end
        end
        else if (head.entry.v_bad > v_w_reg)
            v_w_next = head.entry.v_bad;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_ACC:   if (pop && head.entry.eow) state_next = S_TDIV;
            S_TDIV:  if (div_done) state_next = S_CDIV;
            S_CDIV:  if (div_done) state_next = S_VDIV;
            S_VDIV:  if (div_done) state_next = S_SQRT;
            S_SQRT:  if (sq_cnt_reg == 5'd18) state_next = S_CREST;
            S_CREST: if (div_done) state_next = S_EMIT;
            S_EMIT:  if (load_out) state_next = S_ACC;
            default: state_next = S_ACC;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.entry.eow)
        begin
            st_reg  <= t_tot_next;
            sc_reg  <= c_tot_next;
            sv_reg  <= v_tot_next;
            sp_reg  <= peak_next;
            stc_reg <= t_cnt_next;
            scc_reg <= c_cnt_next;
            svc_reg <= v_cnt_next;
            stw_reg <= t_w_next;
            scw_reg <= c_w_next;
            svw_reg <= v_w_next;
            exp_reg <= (expected == '0) ? 11'd1 : expected;
        end
        if (state_reg == S_TDIV && div_done)
            t_mean_reg <= st_reg[25] ? 16'(-div_q) : div_q[15:0];
        if (state_reg == S_CDIV && div_done)
            c_mean_reg <= sc_reg[24] ? 15'(-div_q) : div_q[14:0];
        if (state_reg == S_VDIV && div_done)
        begin
            x_reg      <= (svc_reg == '0) ? '0 : div_q[37:0];
            rem_reg    <= '0;
            rms_reg    <= '0;
            sq_cnt_reg <= '0;
        end
        if (state_reg == S_SQRT)
        begin
            rem_reg    <= sq_ge ? 22'(r4 - trial) : r4;
            rms_reg    <= {rms_reg[17:0], sq_ge};
            x_reg      <= {x_reg[35:0], 2'b00};
            sq_cnt_reg <= sq_cnt_reg + 1'b1;
        end
        if (state_reg == S_CREST && div_done)
            crest_reg <= (div_q > 48'd65535) ? 16'hFFFF : div_q[15:0];
        if (load_out)
            m_data_reg <= {svc_reg, scc_reg, stc_reg,
                           quality(svw_reg, svc_reg, exp_reg),
                           quality(scw_reg, scc_reg, exp_reg),
                           quality(stw_reg, stc_reg, exp_reg),
                           crest_ok,
                           crest_ok ? crest_reg : 16'd0,
                           sp_reg,
                           rms_reg,
                           (scc_reg == '0) ? 15'd0 : c_mean_reg,
                           (stc_reg == '0) ? 16'd0 : t_mean_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_ACC;
            go_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            t_tot_reg   <= '0;
            c_tot_reg   <= '0;
            v_tot_reg   <= '0;
            peak_reg    <= '0;
            t_cnt_reg   <= '0;
            c_cnt_reg   <= '0;
            v_cnt_reg   <= '0;
            t_w_reg     <= ST_GOOD;
            c_w_reg     <= ST_GOOD;
            v_w_reg     <= ST_GOOD;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= (state_next != state_reg) &&
                         (state_next == S_TDIV || state_next == S_CDIV ||
                          state_next == S_VDIV || state_next == S_CREST);
            if (load_out)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            if (pop)
            begin
                if (head.entry.eow)
                begin
                    t_tot_reg <= '0;
                    c_tot_reg <= '0;
                    v_tot_reg <= '0;
                    peak_reg  <= '0;
                    t_cnt_reg <= '0;
                    c_cnt_reg <= '0;
                    v_cnt_reg <= '0;
                    t_w_reg   <= ST_GOOD;
                    c_w_reg   <= ST_GOOD;
                    v_w_reg   <= ST_GOOD;
                end
                else
                begin
                    t_tot_reg <= t_tot_next;
                    c_tot_reg <= c_tot_next;
                    v_tot_reg <= v_tot_next;
                    peak_reg  <= peak_next;
                    t_cnt_reg <= t_cnt_next;
                    c_cnt_reg <= c_cnt_next;
                    v_cnt_reg <= v_cnt_next;
                    t_w_reg   <= t_w_next;
                    c_w_reg   <= c_w_next;
                    v_w_reg   <= v_w_next;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/sensor_window_statistics.sv
// Windowed sensor statistics. Each beat carries one temperature, current and
// vibration sample with status; the front classifies it and a four-entry
// queue feeds the accumulator, which takes one beat per cycle while no closed
// window is in work. A beat with tlast closes the window. Once that beat
// leaves the queue, the block runs four divisions through one shared 48-step
// bit-serial divider, a square root and the load of the output register
// before the result beat is offered. A result that is still waiting on
// m_tready holds the next window's result back in the same way. Beats keep
// being taken until the queue fills. The window length register (reset 10)
// is sampled as the window closes.
`default_nettype none
module sensor_window_statistics
    import swst_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // temperature, temperature code, current sample, current code,
    // vibration, vibration code, zero fill
    input  wire logic [63:0]  s_tdata,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // temperature mean, current mean, vibration rms, vibration peak,
    // crest factor, crest valid, temperature grade, current grade,
    // vibration grade, temperature count, current count, vibration count
    output logic [127:0]      m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [10:0]  cfg_wdata
);

    q_entry_t    entry;
    q_head_t     head;
    logic        full;
    logic        pop;
    logic [10:0] expected_reg;

    assign s_tready = !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_reg <= EXPECTED_RESET;
        else if (cfg_we)
            expected_reg <= cfg_wdata;
    end

    swst_front u_front (
        .tdata (s_tdata),
        .tlast (s_tlast),
        .entry (entry)
    );

    swst_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (s_tvalid && !full),
        .push_entry (entry),
        .full       (full),
        .pop        (pop),
        .head       (head)
    );

    swst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .pop      (pop),
        .expected (expected_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
